// ----- rtl/sha256_pkg.sv -----
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_PAD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       store_byte;
        logic       start_comp;
        logic       round_en;
        logic       finish_comp;
        logic       pad_fill;
        logic       pad_second;
        logic       reload;
    } cmd_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_FILL = 6'd56;

endpackage

// ----- rtl/sha256_ctrl.sv -----
module sha256_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               has_byte,
    input  logic               is_last,
    input  logic               block_full,
    input  logic               two_blocks,
    input  logic               out_fire,
    output logic               in_ready,
    output logic               out_valid,
    output logic [2:0]         out_index,
    output sha256_pkg::cmd_t   cmd
);

    sha256_pkg::state_t state_reg, state_next;
    logic [5:0] round_reg, round_next;
    logic       last_reg, last_next;
    logic       second_reg, second_next;
    logic       done_reg, done_next;
    logic [2:0] idx_reg, idx_next;

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha256_pkg::ST_IDLE;
            round_reg  <= '0;
            last_reg   <= 1'b0;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            round_reg  <= round_next;
            last_reg   <= last_next;
            second_reg <= second_next;
            done_reg   <= done_next;
            idx_reg    <= idx_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        round_next  = round_reg;
        last_next   = last_reg;
        second_next = second_reg;
        done_next   = done_reg;
        idx_next    = idx_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        out_index   = idx_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.store_byte = has_byte;
                    last_next      = is_last;
                    if (has_byte && block_full)
                    begin
                        cmd.start_comp = 1'b1;
                        round_next     = '0;
                        state_next     = sha256_pkg::ST_COMP;
                    end
                    else if (is_last)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_COMP:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    cmd.finish_comp = 1'b1;
                    if (second_reg)
                    begin
                        cmd.pad_second = 1'b1;
                        second_next    = 1'b0;
                        state_next     = sha256_pkg::ST_PAD;
                    end
                    else if (done_reg)
                    begin
                        done_next  = 1'b0;
                        idx_next   = '0;
                        state_next = sha256_pkg::ST_EMIT;
                    end
                    else if (last_reg)
                    begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                    else
                    begin
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            sha256_pkg::ST_PAD:
            begin
                // Start a tail compression. The first tail block is padded now;
                // a second tail block was written when the first one finished.
                cmd.start_comp = 1'b1;
                round_next     = '0;
                state_next     = sha256_pkg::ST_COMP;
                if (last_reg)
                begin
                    last_next    = 1'b0;
                    cmd.pad_fill = 1'b1;
                    if (two_blocks)
                    begin
                        second_next = 1'b1;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                else
                begin
                    done_next = 1'b1;
                end
            end
            sha256_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.reload = 1'b1;
                        state_next = sha256_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha256_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sha256_dp.sv -----
module sha256_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  sha256_pkg::cmd_t   cmd,
    input  logic [7:0]         data_byte,
    input  logic [2:0]         out_index,
    output logic               block_full,
    output logic               two_blocks,
    output logic [31:0]        digest_word
);

    logic [31:0] blk_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] bits_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic [31:0] w_cur, w_new, s0, s1, sum0, sum1, ch, maj, tmp1, tmp2;
    logic [63:0] total;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    assign block_full  = (fill_reg == 6'd63);
    assign two_blocks  = (fill_reg >= sha256_pkg::LEN_FILL);
    assign total       = bits_reg + {55'd0, fill_reg, 3'd0};
    assign digest_word = h_reg[out_index];

    // Message schedule and round function.
    always_comb
    begin
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = (t_reg == 6'd0) ? blk_reg[0] : ((t_reg < 6'd16) ? w_reg[0] : w_new);
        sum1  = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        tmp1  = v_reg[7] + sum1 + ch + sha256_pkg::ROUND_K[t_reg] + w_cur;
        sum0  = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        tmp2  = sum0 + maj;
    end

    // Block buffer as sixteen big-endian words; padding rewrites the tail bytes.
    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
        begin
            blk_reg[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] <= data_byte;
        end
        if (cmd.pad_fill)
        begin
            for (int i = 0; i < 56; i++)
            begin
                if (i == int'(fill_reg))
                begin
                    blk_reg[i / 4][8 * (3 - i % 4) +: 8] <= sha256_pkg::PAD_BYTE;
                end
                else if (i > int'(fill_reg))
                begin
                    blk_reg[i / 4][8 * (3 - i % 4) +: 8] <= 8'd0;
                end
            end
            // The last eight bytes hold the length, or padding when it spills over.
            for (int j = 0; j < 8; j++)
            begin
                if (!two_blocks)
                begin
                    blk_reg[15 - j / 4][8 * (j % 4) +: 8] <= total[8 * j +: 8];
                end
                else if (63 - j == int'(fill_reg))
                begin
                    blk_reg[15 - j / 4][8 * (j % 4) +: 8] <= sha256_pkg::PAD_BYTE;
                end
                else if (63 - j > int'(fill_reg))
                begin
                    blk_reg[15 - j / 4][8 * (j % 4) +: 8] <= 8'd0;
                end
            end
        end
        if (cmd.pad_second)
        begin
            for (int i = 0; i < 14; i++)
            begin
                blk_reg[i] <= '0;
            end
            blk_reg[14] <= total[63:32];
            blk_reg[15] <= total[31:0];
        end
    end

    // Fill and length counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.store_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
                if (block_full)
                begin
                    bits_reg <= bits_reg + 64'd512;
                end
            end
            if (cmd.reload)
            begin
                fill_reg <= '0;
                bits_reg <= '0;
            end
        end
    end

    // Chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::INIT_HASH[i];
            end
        end
        else if (cmd.finish_comp)
        begin
            h_reg[0] <= h_reg[0] + tmp1 + tmp2;
            h_reg[1] <= h_reg[1] + v_reg[0];
            h_reg[2] <= h_reg[2] + v_reg[1];
            h_reg[3] <= h_reg[3] + v_reg[2];
            h_reg[4] <= h_reg[4] + v_reg[3] + tmp1;
            h_reg[5] <= h_reg[5] + v_reg[4];
            h_reg[6] <= h_reg[6] + v_reg[5];
            h_reg[7] <= h_reg[7] + v_reg[6];
        end
        else if (cmd.reload)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::INIT_HASH[i];
            end
        end
    end

    // Working variables and schedule window, one round per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.start_comp)
        begin
            t_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            t_reg <= t_reg + 6'd1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + tmp1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= tmp1 + tmp2;
            if (t_reg == 6'd0)
            begin
                // Round 0 takes its word straight from the block and loads the rest.
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= blk_reg[i + 1];
                end
                w_reg[15] <= blk_reg[0];
            end
            else
            begin
                for (int i = 0; i < 15; i++)
                begin
                    w_reg[i] <= w_reg[i + 1];
                end
                w_reg[15] <= w_cur;
            end
        end
    end

endmodule

// ----- rtl/sha256_byte_stream_hasher.sv -----
// SHA-256 over a byte stream: at most one byte per accepted beat; a beat with
// is_last finishes the message and returns eight digest beats, word 0 first. A
// byte beat that completes a 64-byte block starts a compression, which runs one
// round per cycle while the input stalls. After the last beat the first digest
// beat is offered once the padded tail is compressed, after the block that beat
// completes, if any, and after a second tail block when the padding spills over.
// The input stays stalled until the eighth digest beat is taken.
module sha256_byte_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        has_byte,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::cmd_t cmd;
    logic in_ready, in_fire, out_fire, block_full, two_blocks;

    assign in_stall   = !in_ready;
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid && !out_stall;
    assign last_word  = (word_index == 3'd7);

    sha256_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .has_byte   (has_byte),
        .is_last    (is_last),
        .block_full (block_full),
        .two_blocks (two_blocks),
        .out_fire   (out_fire),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_index  (word_index),
        .cmd        (cmd)
    );

    sha256_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .data_byte   (data_byte),
        .out_index   (word_index),
        .block_full  (block_full),
        .two_blocks  (two_blocks),
        .digest_word (digest_word)
    );

    // No input beat is taken while digest beats are pending.
    assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
        else $error("input accepted during digest output");

    // A stalled digest beat keeps its word index.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_index))
        else $error("digest index moved under stall");

endmodule

// ----- sim/sha256_digest_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the hasher, computes the digest of each message
// as its bytes are accepted, and compares every digest beat's word, index
// and last flag with the oldest expected beat.
module sha256_digest_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        has_byte,
    input  logic [7:0]  data_byte,
    input  logic        is_last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          words_pending
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [6:0]   block_bytes;
    logic [63:0]  bits_done;
    digest_beat_t digest_queue [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One full 64-round compression of msg_block into hash_state.
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1;
        logic [31:0] t2;
        for (int j = 0; j < 16; j++)
        begin
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        end
        for (int j = 16; j < 64; j++)
        begin
            w[j] = w[j-16] + w[j-7]
                 + (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3))
                 + (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10));
        end
        for (int j = 0; j < 8; j++)
        begin
            v[j] = hash_state[j];
        end
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int j = 0; j < 8; j++)
        begin
            hash_state[j] = hash_state[j] + v[j];
        end
    endtask

    task automatic start_message();
        for (int j = 0; j < 8; j++)
        begin
            hash_state[j] = sha256_pkg::INIT_HASH[j];
        end
        block_bytes = '0;
        bits_done = '0;
    endtask

    // Absorb one accepted beat; a last beat pads, finishes and queues the digest.
    task automatic absorb_beat(input logic hb, input logic [7:0] b, input logic lst);
        logic [63:0]  total;
        int           fill;
        digest_beat_t beat;
        if (hb)
        begin
            msg_block[block_bytes[5:0]] = b;
            block_bytes = block_bytes + 7'd1;
            if (block_bytes == 7'd64)
            begin
                compress_block();
                bits_done = bits_done + 64'd512;
                block_bytes = '0;
            end
        end
        if (lst)
        begin
            fill = int'(block_bytes);
            msg_block[fill] = sha256_pkg::PAD_BYTE;
            for (int i = fill + 1; i < 64; i++)
            begin
                msg_block[i] = 8'h00;
            end
            if (fill >= int'(sha256_pkg::LEN_FILL))
            begin
                compress_block();
                for (int i = 0; i < 64; i++)
                begin
                    msg_block[i] = 8'h00;
                end
            end
            total = bits_done + 64'(fill) * 8;
            for (int j = 0; j < 8; j++)
            begin
                msg_block[63-j] = total[8*j +: 8];
            end
            compress_block();
            for (int j = 0; j < 8; j++)
            begin
                beat.word = hash_state[j];
                beat.index = 3'(j);
                beat.last = (j == 7);
                digest_queue.push_back(beat);
            end
            start_message();
        end
    endtask

    initial
    begin
        start_message();
    end

    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                absorb_beat(has_byte, data_byte, is_last);
            end
            if (out_valid && !out_stall)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest beat: word %h index %0d", digest_word, word_index);
                    fail_count++;
                end
                else
                begin
                    exp_beat = digest_queue.pop_front();
                    if (digest_word !== exp_beat.word)
                    begin
                        $error("digest_word: expected %h, actual %h", exp_beat.word, digest_word);
                        fail_count++;
                    end
                    if (word_index !== exp_beat.index)
                    begin
                        $error("word_index: expected %0d, actual %0d", exp_beat.index, word_index);
                        fail_count++;
                    end
                    if (last_word !== exp_beat.last)
                    begin
                        $error("last_word: expected %0d, actual %0d", exp_beat.last, last_word);
                        fail_count++;
                    end
                end
            end
        end
        words_pending = digest_queue.size();
    end

endmodule

// ----- sim/tb_sha256_byte_stream_hasher.sv -----
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher;

    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_BEATS = 110;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        is_last;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          words_pending;
    int          idle_cycles;
    bit          long_hold;
    bit          hold_done;

    sha256_byte_stream_hasher uut
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .has_byte(has_byte), .data_byte(data_byte), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word)
    );

    sha256_digest_checker checker_i
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .has_byte(has_byte), .data_byte(data_byte), .is_last(is_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .word_index(word_index), .last_word(last_word),
        .fail_count(fail_count), .words_pending(words_pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Send one beat: hold it until accepted. The valid stays high afterwards;
    // the caller lowers it only for a gap or to wait for the digests to drain.
    task automatic send_beat(input logic hb, input logic [7:0] b, input logic lst);
        in_valid <= 1'b1;
        has_byte <= hb;
        data_byte <= b;
        is_last <= lst;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // A message of given length with random bytes; some empty beats mixed in
    // when noisy, and the final byte optionally carried on the last beat.
    task automatic send_message(input int length, input bit noisy);
        bit byte_on_last;
        byte_on_last = length > 0 && $urandom_range(0, 1);
        for (int i = 0; i < length - byte_on_last; i++)
        begin
            if (noisy && $urandom_range(0, 7) == 0)
            begin
                send_beat(1'b0, 8'($urandom), 1'b0);
            end
            send_beat(1'b1, 8'($urandom), 1'b0);
            random_gap();
        end
        send_beat(byte_on_last, 8'($urandom), 1'b1);
        random_gap();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver stall pattern, with one long hold-off when requested.
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (long_hold && !hold_done)
        begin
            hold_done <= 1'b1;
            out_stall <= 1'b1;
            for (hold = 0; hold < 400; hold++)
            begin
                @(posedge clk);
            end
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 9) < 3) && ($time % 2000 > 600);
        end
    end

    // Watchdog on cycles with no accepted beat on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int sent;
        int len;
        rst_n = 1'b0;
        in_valid = 1'b0;
        has_byte = 1'b0;
        data_byte = 8'h00;
        is_last = 1'b0;
        long_hold = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, byte on last, padding boundaries, byte extremes.
        send_beat(1'b0, 8'h00, 1'b1);
        send_beat(1'b1, 8'hff, 1'b1);
        send_beat(1'b1, 8'h00, 1'b1);
        send_beat(1'b0, 8'haa, 1'b0);
        send_beat(1'b1, 8'h55, 1'b0);
        send_beat(1'b0, 8'h00, 1'b1);
        wait_drained();
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b0);
        send_message(64, 1'b0);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering messages.
        long_hold <= 1'b1;
        for (int m = 0; m < 6; m++)
        begin
            send_message($urandom_range(0, 10), 1'b1);
        end
        wait_drained();

        // Random messages, mostly short, a few spanning several blocks.
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            len = $urandom_range(0, 9) == 0 ? $urandom_range(57, 140) : $urandom_range(0, 20);
            send_message(len, 1'b1);
            sent += len + 1;
            if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sha256_pkg.sv
rtl/sha256_ctrl.sv
rtl/sha256_dp.sv
rtl/sha256_byte_stream_hasher.sv
sim/sha256_digest_checker.sv
sim/tb_sha256_byte_stream_hasher.sv
